// File: design/page_bitmap_allocator_assert.svh
// assertion macros for the page bitmap allocator
`ifndef PAGE_BITMAP_ALLOCATOR_ASSERT_SVH
`define PAGE_BITMAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PBA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("page allocator check failed");

// next-cycle implication, disabled during reset
`define PBA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("page allocator check failed");

`endif

// File: design/pba_pkg.sv
// package: widths, register codes and state type of the page bitmap allocator
package pba_pkg;

  localparam int NUM_PAGES   = 128;
  localparam int PIDX_W      = $clog2(NUM_PAGES);
  localparam int PCNT_W      = $clog2(NUM_PAGES + 1);
  localparam int SCAN_W      = PIDX_W + 1;

  localparam int PAGE_SIZE_W = 10;
  localparam int BASE_W      = 16;
  localparam int SIZE_W      = 12;
  localparam int ID_W        = 8;
  localparam int ADDR_W      = 18;
  localparam int COUNT_W     = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  localparam int QUO_W       = SIZE_W + 1;
  localparam int DIVC_W      = $clog2(QUO_W);

  localparam logic [PAGE_SIZE_W-1:0] PAGE_SIZE_RESET = PAGE_SIZE_W'(160);
  localparam logic [BASE_W-1:0]      BASE_RESET      = BASE_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAGE_SIZE    = 2'd0,
    REG_BASE_ADDRESS = 2'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_CHECK,
    S_SCAN,
    S_DONE
  } state_t;

endpackage

// File: design/page_bitmap_allocator.sv
// top level: first-fit page bitmap allocator with a one-bit-per-page memory
// A request passes through an idle state, a bit-serial divider that rounds the size up to
// whole pages, and a check state. It then scans the page memory from page 0 at one entry per
// cycle (one read port, the write-back of a taken page overlapping the next read) until the
// needed pages are marked, and a done state loads the result. Refusals and zero-page requests
// skip the scan. With a zero page size a request skips the divider and is refused. A stall
// on the result holds the block in its done state. After reset a clearing pass marks every
// page free, and no request is accepted until it ends. The result sits in an output register,
// so a request is accepted while an earlier result still waits. The user must write
// configuration only when the block is idle; the block itself does not enforce this. A base
// address write also reloads the bump address.
module page_bitmap_allocator
  import pba_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,

  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,

  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SIZE_W-1:0]      request_size,

  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   granted,
  output logic [ID_W-1:0]        request_id,
  output logic [ADDR_W-1:0]      start_address,
  output logic [SIZE_W-1:0]      granted_size,
  output logic [PAGE_SIZE_W-1:0] unused_space,
  output logic [COUNT_W-1:0]     pages_taken,
  output logic [COUNT_W-1:0]     pages_left
);

  `include "page_bitmap_allocator_assert.svh"

  state_t state, state_next;

  logic [PAGE_SIZE_W-1:0] page_size;
  logic [PCNT_W-1:0]      free_count;
  logic [ADDR_W-1:0]      next_address;
  logic [ID_W-1:0]        next_id;

  logic [SIZE_W-1:0]      size_q;
  logic [QUO_W-1:0]       quo;
  logic [PAGE_SIZE_W-1:0] rem;
  logic [DIVC_W-1:0]      div_cnt;
  logic [PCNT_W-1:0]      need_pg;
  logic [PAGE_SIZE_W-1:0] unused;
  logic                   grant_ok;

  logic                   page_mem [NUM_PAGES];
  logic [PIDX_W-1:0]      clr_idx;
  logic [SCAN_W-1:0]      rd_addr;
  logic                   rd_valid;
  logic [PIDX_W-1:0]      rd_idx;
  logic                   rd_data;
  logic [PCNT_W-1:0]      got;

  logic                   mem_re;
  logic                   mem_we;
  logic [PIDX_W-1:0]      wr_idx;
  logic                   wr_bit;
  logic                   take;
  logic [PCNT_W-1:0]      got_next;
  logic                   out_load;

  logic [PAGE_SIZE_W:0]   div_shift;
  logic                   div_ge;

  assign in_ready  = (state == S_IDLE);
  assign div_shift = {rem, quo[QUO_W-1]};
  assign div_ge    = div_shift >= {1'b0, page_size};

  assign take     = (state == S_SCAN) && rd_valid && !rd_data && (got < need_pg);
  assign got_next = got + PCNT_W'(take);
  assign out_load = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    wr_idx     = rd_idx;
    wr_bit     = 1'b1;
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        wr_idx = clr_idx;
        wr_bit = 1'b0;
        if (clr_idx == PIDX_W'(NUM_PAGES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_next = (page_size == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (div_cnt == DIVC_W'(QUO_W - 1)) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (quo > QUO_W'(free_count) || quo == '0) state_next = S_DONE;
        else state_next = S_SCAN;
      end
      S_SCAN: begin
        mem_re = rd_addr < SCAN_W'(NUM_PAGES);
        mem_we = take;
        if (got_next == need_pg) state_next = S_DONE;
        else if (rd_valid && rd_idx == PIDX_W'(NUM_PAGES - 1)) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  // page memory: one read port, one write port
  always_ff @(posedge clk) begin
    if (mem_re) rd_data <= page_mem[rd_addr[PIDX_W-1:0]];
    if (mem_we) page_mem[wr_idx] <= wr_bit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size    <= PAGE_SIZE_RESET;
      next_address <= ADDR_W'(BASE_RESET);
      free_count   <= PCNT_W'(NUM_PAGES);
      next_id      <= ID_W'(1);
      clr_idx      <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PAGE_SIZE: page_size <= cfg_data[PAGE_SIZE_W-1:0];
          REG_BASE_ADDRESS: next_address <= ADDR_W'(cfg_data[BASE_W-1:0]);
          default: ;
        endcase
      end

      if (state == S_CLEAR) clr_idx <= clr_idx + PIDX_W'(1);

      if (state == S_SCAN) begin
        rd_valid <= mem_re;
        got      <= got_next;
        if (mem_re) begin
          rd_idx  <= rd_addr[PIDX_W-1:0];
          rd_addr <= rd_addr + SCAN_W'(1);
        end
      end else begin
        rd_valid <= 1'b0;
        if (state == S_CHECK) begin
          rd_addr <= '0;
          got     <= '0;
        end
      end

      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (out_load) begin
        granted <= grant_ok;
        if (grant_ok) begin
          request_id    <= next_id;
          start_address <= next_address;
          granted_size  <= size_q;
          unused_space  <= unused;
          pages_taken   <= COUNT_W'(need_pg);
          pages_left    <= COUNT_W'(free_count - need_pg);
          free_count    <= free_count - need_pg;
          next_id       <= next_id + ID_W'(1);
          // allocated bytes equal the size plus the unused tail
          next_address  <= next_address + ADDR_W'(size_q) + ADDR_W'(unused);
        end else begin
          request_id    <= '0;
          start_address <= '0;
          granted_size  <= '0;
          unused_space  <= '0;
          pages_taken   <= '0;
          pages_left    <= COUNT_W'(free_count);
        end
      end
    end
  end

  // divider and request datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        size_q   <= request_size;
        quo      <= QUO_W'(request_size) + QUO_W'(page_size) - QUO_W'(1);
        rem      <= '0;
        div_cnt  <= '0;
        grant_ok <= 1'b0;
      end
      S_DIV: begin
        quo     <= {quo[QUO_W-2:0], div_ge};
        rem     <= div_ge ? PAGE_SIZE_W'(div_shift - {1'b0, page_size})
                          : div_shift[PAGE_SIZE_W-1:0];
        div_cnt <= div_cnt + DIVC_W'(1);
      end
      S_CHECK: begin
        grant_ok <= quo <= QUO_W'(free_count);
        need_pg  <= PCNT_W'(quo);
        // tail of the last page: page size minus one minus the remainder
        unused   <= page_size - PAGE_SIZE_W'(1) - rem;
      end
      default: ;
    endcase
  end

  `PBA_ASSERT_NOW(a_mem_write_phase, clk, rst, mem_we, (state == S_CLEAR || state == S_SCAN))
  `PBA_ASSERT_NOW(a_scan_within_need, clk, rst, (mem_we && state == S_SCAN), (got < need_pg))
  `PBA_ASSERT_NOW(a_grant_fully_found, clk, rst, (out_load && grant_ok), (got == need_pg || need_pg == '0))
  `PBA_ASSERT_NEXT(a_accept_starts, clk, rst, (in_valid && in_ready), (state == S_DIV || state == S_DONE))

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// testbench for the page bitmap allocator: predicted grants and refusals checked beat by beat
module tb;
  import pba_pkg::*;

  // indexes that decode to no register
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic                   granted;
    logic [ID_W-1:0]        request_id;
    logic [ADDR_W-1:0]      start_address;
    logic [SIZE_W-1:0]      granted_size;
    logic [PAGE_SIZE_W-1:0] unused_space;
    logic [COUNT_W-1:0]     pages_taken;
    logic [COUNT_W-1:0]     pages_left;
  } alloc_reply_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [SIZE_W-1:0]      request_size;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   granted;
  logic [ID_W-1:0]        request_id;
  logic [ADDR_W-1:0]      start_address;
  logic [SIZE_W-1:0]      granted_size;
  logic [PAGE_SIZE_W-1:0] unused_space;
  logic [COUNT_W-1:0]     pages_taken;
  logic [COUNT_W-1:0]     pages_left;

  // allocator state as predicted
  logic [PAGE_SIZE_W-1:0] model_page_size;
  logic [ADDR_W-1:0]      bump_address;
  logic [ID_W-1:0]        next_grant_id;
  logic                   page_busy [NUM_PAGES];
  int                     free_pages;
  bit                     id_wrapped;

  alloc_reply_t pending_grants[$];
  alloc_reply_t want_reply;
  alloc_reply_t seen_reply;
  int           mismatch_count = 0;
  bit           gaps_on = 1'b1;
  bit           stalls_on = 1'b1;
  int           stall_left = 0;

  page_bitmap_allocator u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .request_size  (request_size),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .granted       (granted),
    .request_id    (request_id),
    .start_address (start_address),
    .granted_size  (granted_size),
    .unused_space  (unused_space),
    .pages_taken   (pages_taken),
    .pages_left    (pages_left)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // round up to pages, take the lowest free ones, advance id and bump address
  function automatic alloc_reply_t allocate_pages(logic [SIZE_W-1:0] size);
    alloc_reply_t reply;
    int need;
    int taken;
    int bytes;
    reply = '0;
    reply.pages_left = COUNT_W'(free_pages);
    if (model_page_size == '0) return reply;
    need = (int'(size) + int'(model_page_size) - 1) / int'(model_page_size);
    if (need > free_pages) return reply;
    taken = 0;
    for (int i = 0; i < NUM_PAGES && taken < need; i++) begin
      if (!page_busy[i]) begin
        page_busy[i] = 1'b1;
        taken++;
      end
    end
    free_pages -= taken;
    bytes = taken * int'(model_page_size);
    reply.granted       = 1'b1;
    reply.request_id    = next_grant_id;
    reply.start_address = bump_address;
    reply.granted_size  = size;
    reply.unused_space  = PAGE_SIZE_W'(bytes - int'(size));
    reply.pages_taken   = COUNT_W'(taken);
    reply.pages_left    = COUNT_W'(free_pages);
    bump_address = bump_address + ADDR_W'(bytes);
    next_grant_id = next_grant_id + 1'b1;
    if (next_grant_id == '0) id_wrapped = 1'b1;
    return reply;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      REG_PAGE_SIZE:    model_page_size = data[PAGE_SIZE_W-1:0];
      REG_BASE_ADDRESS: bump_address = ADDR_W'(data);
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays up across back-to-back beats, dropped only before a gap or when draining
  task automatic send_request(input logic [SIZE_W-1:0] size);
    int gap;
    if (gaps_on && $urandom_range(0, 99) < 40) gap = pick_idle_len();
    else gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    request_size <= size;
    do @(posedge clk); while (!in_ready);
    pending_grants = {pending_grants, allocate_pages(size)};
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left <= pick_idle_len() - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen_reply = '{granted, request_id, start_address, granted_size,
                     unused_space, pages_taken, pages_left};
      if (pending_grants.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: result beat with nothing outstanding", $realtime);
      end else begin
        want_reply = pending_grants.pop_front();
        if (seen_reply !== want_reply) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: expected g=%0d id=%0d addr=%0d size=%0d unused=%0d taken=%0d left=%0d",
                     $realtime, want_reply.granted, want_reply.request_id,
                     want_reply.start_address, want_reply.granted_size,
                     want_reply.unused_space, want_reply.pages_taken, want_reply.pages_left);
            $display("%0t:      got g=%0d id=%0d addr=%0d size=%0d unused=%0d taken=%0d left=%0d",
                     $realtime, seen_reply.granted, seen_reply.request_id,
                     seen_reply.start_address, seen_reply.granted_size,
                     seen_reply.unused_space, seen_reply.pages_taken, seen_reply.pages_left);
          end
        end
      end
    end
  end

  // reset values, sub-page, exact page and just-over-page sizes, zero size
  task automatic test_reset_defaults();
    send_request(12'd1);
    send_request(12'd160);
    send_request(12'd161);
    send_request(12'd0);
    wait_for_drain();
  endtask

  // every request refused, zero size included
  task automatic test_zero_page_size();
    write_reg(REG_PAGE_SIZE, 16'd0);
    send_request(12'd0);
    send_request(12'd4095);
    send_request(12'd1);
    wait_for_drain();
  endtask

  task automatic test_largest_page();
    write_reg(REG_PAGE_SIZE, 16'd1023);
    write_reg(REG_BASE_ADDRESS, 16'hFFFF);
    send_request(12'd4095);
    send_request(12'd1023);
    send_request(12'd1024);
    wait_for_drain();
  endtask

  task automatic test_unit_page();
    write_reg(REG_PAGE_SIZE, 16'd1);
    write_reg(REG_BASE_ADDRESS, 16'd0);
    send_request(12'd1);
    send_request(12'd2);
    send_request(12'd4095);
    send_request(12'd2048);
    wait_for_drain();
  endtask

  // spare indexes ignored, page size takes only its low bits
  task automatic test_register_decode();
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hA5A5);
    write_reg(REG_PAGE_SIZE, 16'hFEAA);
    send_request(12'd1364);
    send_request(12'd683);
    wait_for_drain();
  endtask

  task automatic test_random_phases();
    logic [PAGE_SIZE_W-1:0]            ps_value;
    logic [CFG_DATA_W-PAGE_SIZE_W-1:0] junk;
    logic [CFG_DATA_W-1:0]             base_value;
    int items;
    int ps;
    int r;
    int v;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0:       ps_value = 10'd1;
        1:       ps_value = PAGE_SIZE_W'($urandom_range(2, 63));
        2:       ps_value = 10'd0;
        3:       ps_value = PAGE_SIZE_W'($urandom_range(1, 1023));
        4:       ps_value = PAGE_SIZE_W'($urandom_range(200, 1022));
        default: ps_value = 10'd1023;
      endcase
      if (k == 0) base_value = '0;
      else if (k == 5) base_value = '1;
      else base_value = CFG_DATA_W'($urandom_range(0, 65535));
      junk = (CFG_DATA_W-PAGE_SIZE_W)'($urandom);
      write_reg(REG_PAGE_SIZE, {junk, ps_value});
      write_reg(REG_BASE_ADDRESS, base_value);
      gaps_on   = (k % 3 != 1);
      stalls_on = (k % 3 != 2);
      items = (k == 2) ? 30 : 100;
      ps = int'(model_page_size);
      repeat (items) begin
        r = $urandom_range(0, 99);
        if (r < 20) begin
          v = 0;
        end else if (r < 35) begin
          v = $urandom_range(1, (ps > 0) ? ps : 1);
        end else if (r < 45) begin
          // just under, on and just over a page multiple
          v = $urandom_range(1, 4) * ps + $urandom_range(0, 2) - 1;
        end else if (r < 60) begin
          v = 4095;
        end else begin
          v = $urandom_range(0, 4095);
        end
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        send_request(SIZE_W'(v));
      end
      wait_for_drain();
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // take every remaining page in one exact fit, then run dry
  task automatic test_exhaustion();
    write_reg(REG_PAGE_SIZE, 16'd32);
    write_reg(REG_BASE_ADDRESS, 16'h8000);
    if (free_pages > 0) send_request(SIZE_W'(free_pages * 32));
    send_request(12'd1);
    send_request(12'd0);
    send_request(12'd4095);
    wait_for_drain();
  endtask

  // zero-size grants until the id counter wraps through zero
  task automatic test_id_wrap();
    for (int n = 0; n < 300 && !id_wrapped; n++) send_request(12'd0);
    send_request(12'd0);
    send_request(12'd0);
    wait_for_drain();
  endtask

  initial begin
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_index    = REG_PAGE_SIZE;
    cfg_data     = '0;
    in_valid     = 1'b0;
    request_size = '0;
    model_page_size = PAGE_SIZE_RESET;
    bump_address    = ADDR_W'(BASE_RESET);
    next_grant_id   = 8'd1;
    foreach (page_busy[i]) page_busy[i] = 1'b0;
    free_pages = NUM_PAGES;
    id_wrapped = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_zero_page_size();
    test_largest_page();
    test_unit_page();
    test_register_decode();
    test_random_phases();
    test_exhaustion();
    test_id_wrap();

    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && pending_grants.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/pba_pkg.sv
design/page_bitmap_allocator.sv
tb/tb.sv
